FILE: rtl/core/mvs_pkg.sv
package mvs_pkg;

   // Sizing of the voice table and the tick compare
   localparam int VOICES    = 16;
   localparam int TIME_BITS = 32;

   // Fixed port widths
   localparam int TICK_W  = 32;
   localparam int FIELD_W = 5;

   // Voice numbers count from 1, so they need room for VOICES itself
   localparam int VNUM_W = $clog2(VOICES + 1);
   localparam int CMP_W  = (VNUM_W > FIELD_W) ? VNUM_W : FIELD_W;

   typedef logic [TIME_BITS-1:0] time_type;
   typedef logic [VNUM_W-1:0]    vnum_type;
   typedef logic [FIELD_W-1:0]   field_type;
   typedef logic [TICK_W-1:0]    tick_type;

   // Request kinds
   localparam logic REQ_ASSIGN = 1'b0;
   localparam logic REQ_CLEAR  = 1'b1;

   localparam field_type CSR_VOICES_RESET = field_type'(16);

   // Commit of one beat into the voice table
   typedef struct packed {
      logic commit;
      logic clear;
   } tbl_cmd_type;

   // First-fit lookup for the beat in the input register
   typedef struct packed {
      logic     found;
      vnum_type voice_num;
      vnum_type highest;
      vnum_type highest_next;
   } tbl_look_type;

   // Ticks are taken modulo 2^TIME_BITS
   function automatic time_type to_time(input tick_type tick);
      logic [63:0] wide;
      wide = 64'(tick);
      return wide[TIME_BITS-1:0];
   endfunction

endpackage

FILE: rtl/core/mvs_voice_table.sv
module mvs_voice_table (
   input  logic                    clock,
   input  logic                    reset,
   input  mvs_pkg::field_type      limit,
   input  mvs_pkg::time_type       note_start,
   input  mvs_pkg::time_type       note_end,
   input  mvs_pkg::tbl_cmd_type    cmd,
   output mvs_pkg::tbl_look_type   look
);

   logic [mvs_pkg::VOICES-1:0] busy_ff;
   logic [mvs_pkg::VOICES-1:0] busy_in;
   mvs_pkg::time_type          last_end_ff [mvs_pkg::VOICES];
   mvs_pkg::vnum_type          highest_ff;
   mvs_pkg::vnum_type          highest_in;

   logic [mvs_pkg::VOICES-1:0] free;
   logic [mvs_pkg::VOICES-1:0] pick;
   mvs_pkg::vnum_type          voice_num;

   // Free voice: allowed, and either never used or ended strictly before start
   always_comb begin
      for (int v = 0; v < mvs_pkg::VOICES; v++) begin
         free[v] = (mvs_pkg::CMP_W'(v) < mvs_pkg::CMP_W'(limit)) &&
                   (!busy_ff[v] || (note_start > last_end_ff[v]));
      end
   end

   // Isolate the lowest free voice
   assign pick = free & (~free + mvs_pkg::VOICES'(1));

   always_comb begin
      voice_num = '0;
      for (int v = 0; v < mvs_pkg::VOICES; v++) begin
         if (pick[v]) begin
            voice_num = voice_num | mvs_pkg::vnum_type'(v + 1);
         end
      end
   end

   assign look.found        = |free;
   assign look.voice_num    = voice_num;
   assign look.highest      = highest_ff;
   assign look.highest_next = (look.found && (voice_num > highest_ff)) ? voice_num : highest_ff;

   always_comb begin
      busy_in    = busy_ff;
      highest_in = highest_ff;
      if (cmd.commit) begin
         if (cmd.clear) begin
            busy_in    = '0;
            highest_in = '0;
         end else begin
            busy_in    = busy_ff | pick;
            highest_in = look.highest_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= '0;
         highest_ff <= '0;
      end else begin
         busy_ff    <= busy_in;
         highest_ff <= highest_in;
      end
   end

   // End ticks are only read behind a busy bit
   always_ff @(posedge clock) begin
      for (int v = 0; v < mvs_pkg::VOICES; v++) begin
         if (cmd.commit && !cmd.clear && pick[v]) begin
            last_end_ff[v] <= note_end;
         end
      end
   end

   a_pick_onehot : assert property (@(posedge clock) disable iff (reset)
      $onehot0(pick))
      else $error("voice pick is not one-hot");

   a_clear_empties : assert property (@(posedge clock) disable iff (reset)
      cmd.commit && cmd.clear |=> busy_ff == '0 && highest_ff == '0)
      else $error("clear left voices in use");

   a_highest_covers : assert property (@(posedge clock) disable iff (reset)
      look.found |-> look.highest_next >= look.voice_num)
      else $error("highest voice below assigned voice");

endmodule

FILE: rtl/core/monophonic_voice_splitter.sv
// Path: an accepted beat waits in the input register, then moves into the result register
//   and shows on rsp_*; rsp_stall on a full result register can hold it in the input register.
// Throughput: one note or clear per cycle while rsp_stall does not hold the result register;
//   the parallel compare against every voice's last end tick and the first-fit pick are combinational.
// Reset: synchronous, active high; empties both pipeline registers, forgets every
//   voice and sets the voice limit to 16. There is no clearing pass.
module monophonic_voice_splitter (
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_type,
   input  mvs_pkg::tick_type      req_note_start,
   input  mvs_pkg::tick_type      req_note_end,
   // response channel
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output mvs_pkg::field_type     rsp_voice,
   output logic                   rsp_no_voice,
   output mvs_pkg::field_type     rsp_max_polyphony,
   // configuration
   input  logic                   csr_wr_en,
   input  mvs_pkg::field_type     csr_wr_data
);

   // Configuration register: number of voices that may be assigned
   mvs_pkg::field_type csr_voices_ff;
   mvs_pkg::field_type csr_voices_in;

   // Input register
   logic               s1_vld_ff;
   logic               s1_vld_in;
   logic               s1_clear_ff;
   mvs_pkg::time_type  s1_start_ff;
   mvs_pkg::time_type  s1_end_ff;

   // Result register
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   mvs_pkg::field_type rsp_voice_ff;
   mvs_pkg::field_type rsp_voice_in;
   logic               rsp_no_voice_ff;
   logic               rsp_no_voice_in;
   mvs_pkg::field_type rsp_poly_ff;
   mvs_pkg::field_type rsp_poly_in;

   logic                  out_ready;
   logic                  s1_advance;
   logic                  req_accept;
   mvs_pkg::tbl_cmd_type  tbl_cmd;
   mvs_pkg::tbl_look_type tbl_look;

   // Handshake: the result register frees up when empty or being taken,
   // and the input register drains into it whenever it does.
   assign out_ready  = !rsp_valid_ff || !rsp_stall;
   assign s1_advance = s1_vld_ff && out_ready;
   assign req_stall  = s1_vld_ff && !out_ready;
   assign req_accept = req_valid && !req_stall;

   assign csr_voices_in = csr_wr_en ? csr_wr_data : csr_voices_ff;

   always_comb begin
      s1_vld_in = s1_vld_ff;
      if (req_accept) begin
         s1_vld_in = 1'b1;
      end else if (s1_advance) begin
         s1_vld_in = 1'b0;
      end
   end

   // Commit the beat to the voice table as it moves into the result register
   assign tbl_cmd.commit = s1_advance;
   assign tbl_cmd.clear  = s1_clear_ff;

   mvs_voice_table u_table (
      .clock      (clock),
      .reset      (reset),
      .limit      (csr_voices_ff),
      .note_start (s1_start_ff),
      .note_end   (s1_end_ff),
      .cmd        (tbl_cmd),
      .look       (tbl_look)
   );

   // Build the result beat; voice numbers are cut to the port width
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_advance) begin
         rsp_valid_in = 1'b1;
      end else if (out_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (s1_clear_ff) begin
         rsp_voice_in    = '0;
         rsp_no_voice_in = 1'b0;
         rsp_poly_in     = '0;
      end else if (tbl_look.found) begin
         rsp_voice_in    = mvs_pkg::field_type'(tbl_look.voice_num);
         rsp_no_voice_in = 1'b0;
         rsp_poly_in     = mvs_pkg::field_type'(tbl_look.highest_next);
      end else begin
         rsp_voice_in    = '0;
         rsp_no_voice_in = 1'b1;
         rsp_poly_in     = mvs_pkg::field_type'(tbl_look.highest);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_voices_ff <= mvs_pkg::CSR_VOICES_RESET;
         s1_vld_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         csr_voices_ff <= csr_voices_in;
         s1_vld_ff     <= s1_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload: load the input register on accept, the result register on advance
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_clear_ff <= (req_type == mvs_pkg::REQ_CLEAR);
         s1_start_ff <= mvs_pkg::to_time(req_note_start);
         s1_end_ff   <= mvs_pkg::to_time(req_note_end);
      end
      if (s1_advance) begin
         rsp_voice_ff    <= rsp_voice_in;
         rsp_no_voice_ff <= rsp_no_voice_in;
         rsp_poly_ff     <= rsp_poly_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_voice         = rsp_voice_ff;
   assign rsp_no_voice      = rsp_no_voice_ff;
   assign rsp_max_polyphony = rsp_poly_ff;

   a_stall_only_when_full : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_vld_ff && rsp_valid_ff)
      else $error("request stalled with room in the pipeline");

   a_no_voice_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_no_voice |-> rsp_voice == '0)
      else $error("voice given together with no_voice");

   a_clear_result : assert property (@(posedge clock) disable iff (reset)
      s1_advance && s1_clear_ff |=>
         rsp_valid && rsp_voice == '0 && !rsp_no_voice && rsp_max_polyphony == '0)
      else $error("clear beat gave a nonzero result");

endmodule

FILE: dv/mvs_voice_checker.sv
module mvs_voice_checker
   import mvs_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   input  logic      req_stall,
   input  logic      req_type,
   input  tick_type  req_note_start,
   input  tick_type  req_note_end,
   input  logic      rsp_valid,
   input  logic      rsp_stall,
   input  field_type rsp_voice,
   input  logic      rsp_no_voice,
   input  field_type rsp_max_polyphony,
   input  logic      csr_wr_en,
   input  field_type csr_wr_data,
   output int        mismatch_count,
   output int        answers_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      field_type voice;
      logic      no_voice;
      field_type max_poly;
   } voice_answer_type;

   // Shadow copy of the voice table and the voice limit register
   logic      voice_used [VOICES];
   time_type  voice_end  [VOICES];
   vnum_type  top_voice;
   field_type voice_limit;

   voice_answer_type voice_answers[$];
   int errors  = 0;
   int waiting = 0;

   assign mismatch_count  = errors;
   assign answers_pending = waiting;

   task automatic flag_mismatch(input string msg);
      errors++;
      $display("%0t ns  mismatch: %s", $time, msg);
   endtask

   task automatic forget_voices();
      for (int v = 0; v < VOICES; v++) begin
         voice_used[v] = 1'b0;
         voice_end[v]  = '0;
      end
      top_voice = '0;
   endtask

   // First fit: lowest voice that is free or whose last end lies strictly before start
   task automatic place_note(input logic kind, input tick_type s, input tick_type e);
      voice_answer_type ans;
      int               limit;
      int               pick;
      time_type         st;
      if (kind == REQ_CLEAR) begin
         forget_voices();
         ans = '{voice: '0, no_voice: 1'b0, max_poly: '0};
         voice_answers.push_back(ans);
         return;
      end
      limit = (int'(voice_limit) > VOICES) ? VOICES : int'(voice_limit);
      pick  = 0;
      st    = time_type'(s);
      for (int v = 0; v < limit; v++)
         if (pick == 0 && (!voice_used[v] || st > voice_end[v]))
            pick = v + 1;
      if (pick == 0) begin
         ans = '{voice: '0, no_voice: 1'b1, max_poly: field_type'(top_voice)};
      end else begin
         voice_used[pick-1] = 1'b1;
         voice_end[pick-1]  = time_type'(e);
         if (pick > int'(top_voice))
            top_voice = vnum_type'(pick);
         ans = '{voice: field_type'(pick), no_voice: 1'b0, max_poly: field_type'(top_voice)};
      end
      voice_answers.push_back(ans);
   endtask

   task automatic compare_answer();
      voice_answer_type want;
      if (voice_answers.size() == 0) begin
         flag_mismatch($sformatf("result with none expected (voice %0d)", rsp_voice));
         return;
      end
      want = voice_answers.pop_front();
      if (rsp_voice !== want.voice)
         flag_mismatch($sformatf("voice %0d, expected %0d", rsp_voice, want.voice));
      if (rsp_no_voice !== want.no_voice)
         flag_mismatch($sformatf("no_voice %0b, expected %0b", rsp_no_voice, want.no_voice));
      if (rsp_max_polyphony !== want.max_poly)
         flag_mismatch($sformatf("max_polyphony %0d, expected %0d",
                                 rsp_max_polyphony, want.max_poly));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         forget_voices();
         voice_limit = CSR_VOICES_RESET;
         voice_answers.delete();
      end else begin
         if ($isunknown(rsp_valid))
            flag_mismatch("rsp_valid unknown");
         else if (rsp_valid && !rsp_stall)
            compare_answer();
         if (req_valid && !req_stall)
            place_note(req_type, req_note_start, req_note_end);
         if (csr_wr_en)
            voice_limit = csr_wr_data;
      end
      waiting = voice_answers.size();
   end

endmodule

FILE: dv/tb_top.sv
module tb_top;
   import mvs_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_PERIOD     = 20;
   localparam int RESET_CYCLES   = 5;
   localparam int PHASE_BEATS    = 52;
   localparam int WATCHDOG_LIMIT = 2000;
   // Post-drain wait before the final check
   localparam int DRAIN_CYCLES   = 10;

   logic      clock = 1'b0;
   logic      reset = 1'b1;

   logic      req_valid      = 1'b0;
   logic      req_stall;
   logic      req_type       = REQ_ASSIGN;
   tick_type  req_note_start = '0;
   tick_type  req_note_end   = '0;

   logic      rsp_valid;
   logic      rsp_stall = 1'b0;
   field_type rsp_voice;
   logic      rsp_no_voice;
   field_type rsp_max_polyphony;

   logic      csr_wr_en   = 1'b0;
   field_type csr_wr_data = '0;

   int        mismatch_count;
   int        answers_pending;

   // Set for the last phase: no sender gaps and no receiver stalls
   logic      quiet = 1'b0;
   int        beats_sent = 0;
   int        stall_left = 0;
   int        idle_cycles = 0;

   always #(CLK_PERIOD/2) clock = ~clock;

   monophonic_voice_splitter dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_type          (req_type),
      .req_note_start    (req_note_start),
      .req_note_end      (req_note_end),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_voice         (rsp_voice),
      .rsp_no_voice      (rsp_no_voice),
      .rsp_max_polyphony (rsp_max_polyphony),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   mvs_voice_checker voice_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_type          (req_type),
      .req_note_start    (req_note_start),
      .req_note_end      (req_note_end),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_voice         (rsp_voice),
      .rsp_no_voice      (rsp_no_voice),
      .rsp_max_polyphony (rsp_max_polyphony),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .mismatch_count    (mismatch_count),
      .answers_pending   (answers_pending)
   );

   // Receiver: stall in random bursts, one assignment per falling edge
   always @(negedge clock) begin
      if (!quiet && stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 6) == 0) begin
         stall_left = $urandom_range(1, 12) - 1;
         rsp_stall <= 1'b1;
      end else begin
         stall_left = 0;
         rsp_stall <= 1'b0;
      end
   end

   // Watchdog: count cycles in which neither channel moves a beat
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("monophonic_voice_splitter test failed");
            $finish;
         end
      end
   end

   // Drive one beat, starting and ending on a falling edge. An optional gap drops
   // valid first; otherwise valid stays high straight from the previous beat.
   task automatic send_beat(input logic kind, input tick_type s, input tick_type e);
      int gap;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 12);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_type       <= kind;
      req_note_start <= s;
      req_note_end   <= e;
      // hold the payload until the beat is taken
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      beats_sent++;
   endtask

   // Drop valid and wait until every expected result has come back
   task automatic hold_until_drained();
      req_valid <= 1'b0;
      while (answers_pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // The voice limit is only written with the block idle
   task automatic write_voice_limit(input field_type value);
      hold_until_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // One track: a clear, then notes in rising start order with random spacing and
   // lengths. Chords stack notes on one start to use up the voices; a little noise
   // (arbitrary ticks, starts out of order, ends below starts) is mixed in.
   task automatic play_track(input int notes);
      tick_type t;
      tick_type dur;
      tick_type prev_end;
      int       chord_left;
      chord_left = 0;
      case ($urandom_range(0, 3))
         0:       t = '0;
         1:       t = $urandom();
         2:       t = 32'hFFFF_FFFF - $urandom_range(0, 4000);
         default: t = $urandom_range(0, 1000);
      endcase
      prev_end = t;
      send_beat(REQ_CLEAR, $urandom(), $urandom());
      for (int i = 0; i < notes; i++) begin
         if ($urandom_range(0, 19) == 0) begin
            send_beat(REQ_ASSIGN, $urandom(), $urandom());
            continue;
         end
         if (chord_left == 0 && $urandom_range(0, 11) == 0)
            chord_left = $urandom_range(4, 20);
         if (chord_left > 0) begin
            // advance nothing: same start, long notes
            chord_left--;
            dur = $urandom_range(16, 400);
         end else begin
            case ($urandom_range(0, 5))
               0, 1:    ;
               2:       if (prev_end >= t) t = prev_end;   // touch the last end
               default: t = t + $urandom_range(1, 24);
            endcase
            case ($urandom_range(0, 9))
               0:          dur = '0;
               1, 2, 3:    dur = $urandom_range(0, 8);
               4, 5, 6:    dur = $urandom_range(0, 60);
               7:          dur = $urandom();
               default:    dur = $urandom_range(0, 20);
            endcase
         end
         prev_end = t + dur;
         send_beat(REQ_ASSIGN, t, prev_end);
      end
   endtask

   initial begin
      field_type phase_limit [9];
      int        goal;

      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part with the reset limit of 16 voices
      send_beat(REQ_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);  // ticks ignored on clear
      send_beat(REQ_ASSIGN, 32'd0, 32'd0);
      send_beat(REQ_ASSIGN, 32'd0, 32'd5);                  // equal ticks overlap
      send_beat(REQ_ASSIGN, 32'd1, 32'd1);
      send_beat(REQ_ASSIGN, 32'd5, 32'd9);
      send_beat(REQ_ASSIGN, 32'd5, 32'd7);
      send_beat(REQ_ASSIGN, 32'd6, 32'd6);
      send_beat(REQ_ASSIGN, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_beat(REQ_ASSIGN, 32'hFFFF_FFFF, 32'd10);         // end below start
      send_beat(REQ_ASSIGN, 32'd3, 32'd3);                  // start out of order
      send_beat(REQ_ASSIGN, 32'd11, 32'd0);
      send_beat(REQ_CLEAR, 32'd0, 32'd0);

      // Four voices: fill them, then one note finds no voice
      write_voice_limit(field_type'(4));
      repeat (5) send_beat(REQ_ASSIGN, 32'd100, 32'd200);

      // Zero voices: every note is refused
      write_voice_limit(field_type'(0));
      send_beat(REQ_ASSIGN, 32'd0, 32'd0);
      send_beat(REQ_ASSIGN, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

      // Random phases, each under its own voice limit; above 16 saturates
      phase_limit = '{field_type'(31), field_type'(1), field_type'(0), field_type'(16),
                      field_type'(17), field_type'(2),
                      field_type'($urandom_range(1, 16)), field_type'(16),
                      field_type'(16)};
      for (int p = 0; p < 9; p++) begin
         write_voice_limit(phase_limit[p]);
         if (p == 8)
            quiet = 1'b1;
         goal = beats_sent + PHASE_BEATS;
         while (beats_sent < goal) begin
            play_track($urandom_range(1, 40));
            // pause the sender now and then until every result is back
            if (!quiet && $urandom_range(0, 3) == 0)
               hold_until_drained();
         end
      end

      req_valid <= 1'b0;
      while (answers_pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && answers_pending == 0)
         $display("monophonic_voice_splitter test passed");
      else
         $display("monophonic_voice_splitter test failed");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/core/mvs_pkg.sv
rtl/core/mvs_voice_table.sv
rtl/core/monophonic_voice_splitter.sv
dv/mvs_voice_checker.sv
dv/tb_top.sv
